// ===== sv/assert_macros.svh =====
// Assertion macros for the reservation table RTL.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off while reset is low.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/iprt_pkg.sv =====
// Package for the I/O port range reservation table: sizes, codes and payload types.
// No dependencies.
`default_nettype none

package iprt_pkg;

  localparam int MAP_ENTRIES = 32;
  localparam int PORT_SPACE  = 65536;

  localparam int IDX_W = $clog2(MAP_ENTRIES);
  localparam int CNT_W = $clog2(MAP_ENTRIES + 1);
  localparam int END_W = $clog2(PORT_SPACE) + 1;
  localparam int SUM_W = 18;

  localparam logic [1:0] REQ_RESERVE = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_CHECK   = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_OVERLAP   = 3'd1;
  localparam logic [2:0] ST_FULL      = 3'd2;
  localparam logic [2:0] ST_RANGE     = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic [1:0] CFG_WA_FIRST = 2'd0;
  localparam logic [1:0] CFG_WA_LAST  = 2'd1;
  localparam logic [1:0] CFG_WB_FIRST = 2'd2;
  localparam logic [1:0] CFG_WB_LAST  = 2'd3;

  localparam logic [15:0] WA_FIRST_RST = 16'h02b0;
  localparam logic [15:0] WA_LAST_RST  = 16'h02df;
  localparam logic [15:0] WB_FIRST_RST = 16'h03c0;
  localparam logic [15:0] WB_LAST_RST  = 16'h03da;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] port_start;
    logic [16:0] length_count;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] granted_start;
    logic [5:0]  entries_used;
    logic [31:0] table_version;
  } out_rsp_t;

  typedef struct packed {
    logic [15:0]      first;
    logic [END_W-1:0] last_end;
  } entry_t;

endpackage

`default_nettype wire

// ===== sv/io_port_range_reservation_table_top.sv =====
// I/O port range reservation table: sequencer, entry table and shared compare step.
// Depends on iprt_pkg and assert_macros.svh.
// Each request scans the entry table, one entry compared per cycle, before out_valid rises.
// Throughput: one request at a time; in_ready returns once the result is loaded.
// Reset: sync active-low; clears count, version, handshake state and restores windows.
`default_nettype none
`include "assert_macros.svh"

module io_port_range_reservation_table_top (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire iprt_pkg::in_req_t in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output iprt_pkg::out_rsp_t     out_data,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RESP} state_t;

  state_t state_r, state_nxt;

  logic [iprt_pkg::CNT_W-1:0] idx_r, idx_nxt;
  logic [iprt_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]                ver_r, ver_nxt;
  logic [1:0]                 req_r, req_nxt;
  logic [15:0]                first_r, first_nxt;
  logic [iprt_pkg::SUM_W-1:0] end_r, end_nxt;
  logic [2:0]                 status_r, status_nxt;
  logic [15:0]                granted_r, granted_nxt;
  logic                       out_valid_r, out_valid_nxt;
  iprt_pkg::out_rsp_t         out_data_r, out_data_nxt;
  logic [15:0]                wa_first_r, wa_last_r, wb_first_r, wb_last_r;

  iprt_pkg::entry_t tab_r   [iprt_pkg::MAP_ENTRIES];
  iprt_pkg::entry_t tab_nxt [iprt_pkg::MAP_ENTRIES];

  iprt_pkg::entry_t           e;
  logic                       at_end;
  logic                       ins_en, del_en;
  logic [iprt_pkg::SUM_W-1:0] e_first, e_end;
  logic                       in_win;
  logic                       hit;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // shared compare step on the entry under the scan pointer
  always_comb begin
    e       = tab_r[idx_r[iprt_pkg::IDX_W-1:0]];
    at_end  = (idx_r == cnt_r);
    e_first = iprt_pkg::SUM_W'(e.first);
    e_end   = iprt_pkg::SUM_W'(e.last_end);
    in_win  = ((first_r >= wa_first_r) &&
               (end_r <= iprt_pkg::SUM_W'(wa_last_r) + iprt_pkg::SUM_W'(1))) ||
              ((first_r >= wb_first_r) &&
               (end_r <= iprt_pkg::SUM_W'(wb_last_r) + iprt_pkg::SUM_W'(1)));
    hit     = ((iprt_pkg::SUM_W'(first_r) >= e_first) && (iprt_pkg::SUM_W'(first_r) < e_end)) ||
              ((iprt_pkg::SUM_W'(first_r) <= e_first) && (end_r > e_first));
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    ver_nxt       = ver_r;
    req_nxt       = req_r;
    first_nxt     = first_r;
    end_nxt       = end_r;
    status_nxt    = status_r;
    granted_nxt   = granted_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ins_en        = 1'b0;
    del_en        = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data.req_type;
          first_nxt = in_data.port_start;
          end_nxt   = iprt_pkg::SUM_W'(in_data.port_start) +
                      iprt_pkg::SUM_W'(in_data.length_count);
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        granted_nxt = '0;
        case (req_r)
          iprt_pkg::REQ_RESERVE: begin
            if (end_r > iprt_pkg::SUM_W'(iprt_pkg::PORT_SPACE)) begin
              status_nxt = iprt_pkg::ST_RANGE;
              state_nxt  = S_RESP;
            end else if (!at_end && (e_end <= iprt_pkg::SUM_W'(first_r))) begin
              idx_nxt = idx_r + iprt_pkg::CNT_W'(1);
            end else if (at_end || (e_first >= end_r)) begin
              state_nxt = S_RESP;
              if (cnt_r == iprt_pkg::CNT_W'(iprt_pkg::MAP_ENTRIES)) begin
                status_nxt = iprt_pkg::ST_FULL;
              end else begin
                status_nxt  = iprt_pkg::ST_OK;
                granted_nxt = first_r;
                ins_en      = 1'b1;
                cnt_nxt     = cnt_r + iprt_pkg::CNT_W'(1);
                ver_nxt     = ver_r + 32'd1;
              end
            end else begin
              status_nxt = iprt_pkg::ST_OVERLAP;
              state_nxt  = S_RESP;
            end
          end
          iprt_pkg::REQ_FREE: begin
            if (at_end || (e.first > first_r)) begin
              status_nxt = iprt_pkg::ST_NOT_FOUND;
              ver_nxt    = ver_r + 32'd1;
              state_nxt  = S_RESP;
            end else if (e.first == first_r) begin
              status_nxt = iprt_pkg::ST_OK;
              del_en     = 1'b1;
              cnt_nxt    = cnt_r - iprt_pkg::CNT_W'(1);
              ver_nxt    = ver_r + 32'd1;
              state_nxt  = S_RESP;
            end else begin
              idx_nxt = idx_r + iprt_pkg::CNT_W'(1);
            end
          end
          iprt_pkg::REQ_CHECK: begin
            if (in_win || at_end) begin
              status_nxt = iprt_pkg::ST_OK;
              state_nxt  = S_RESP;
            end else if (hit) begin
              status_nxt = iprt_pkg::ST_OVERLAP;
              state_nxt  = S_RESP;
            end else begin
              idx_nxt = idx_r + iprt_pkg::CNT_W'(1);
            end
          end
          default: begin
            status_nxt = iprt_pkg::ST_OK;
            state_nxt  = S_RESP;
          end
        endcase
      end
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.status        = status_r;
          out_data_nxt.granted_start = granted_r;
          out_data_nxt.entries_used  = 6'(cnt_r);
          out_data_nxt.table_version = ver_r;
          out_valid_nxt              = 1'b1;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // insert opens a slot at the scan pointer; delete closes it
  always_comb begin
    tab_nxt = tab_r;
    if (ins_en) begin
      for (int i = 1; i < iprt_pkg::MAP_ENTRIES; i++) begin
        if (iprt_pkg::CNT_W'(i) > idx_r) begin
          tab_nxt[i] = tab_r[i-1];
        end
      end
      tab_nxt[idx_r[iprt_pkg::IDX_W-1:0]].first    = first_r;
      tab_nxt[idx_r[iprt_pkg::IDX_W-1:0]].last_end = end_r[iprt_pkg::END_W-1:0];
    end else if (del_en) begin
      for (int i = 0; i < iprt_pkg::MAP_ENTRIES - 1; i++) begin
        if (iprt_pkg::CNT_W'(i) >= idx_r) begin
          tab_nxt[i] = tab_r[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ver_r       <= '0;
      out_valid_r <= 1'b0;
      wa_first_r  <= iprt_pkg::WA_FIRST_RST;
      wa_last_r   <= iprt_pkg::WA_LAST_RST;
      wb_first_r  <= iprt_pkg::WB_FIRST_RST;
      wb_last_r   <= iprt_pkg::WB_LAST_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ver_r       <= ver_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          iprt_pkg::CFG_WA_FIRST: wa_first_r <= cfg_wdata;
          iprt_pkg::CFG_WA_LAST:  wa_last_r  <= cfg_wdata;
          iprt_pkg::CFG_WB_FIRST: wb_first_r <= cfg_wdata;
          iprt_pkg::CFG_WB_LAST:  wb_last_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
    idx_r      <= idx_nxt;
    req_r      <= req_nxt;
    first_r    <= first_nxt;
    end_r      <= end_nxt;
    status_r   <= status_nxt;
    granted_r  <= granted_nxt;
    out_data_r <= out_data_nxt;
    tab_r      <= tab_nxt;
  end

  `ASSERT_ALWAYS(a_cnt_bound, !rst_n || (cnt_r <= iprt_pkg::CNT_W'(iprt_pkg::MAP_ENTRIES)), "entry count over capacity")
  `ASSERT_CLK(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "accepted while busy")
  `ASSERT_CLK(a_ver_step, (ver_r == $past(ver_r)) || (ver_r == $past(ver_r) + 32'd1), "version jumped")
  `ASSERT_CLK(a_cnt_only_in_scan, (cnt_r != $past(cnt_r)) |-> ($past(state_r) == S_SCAN), "count changed outside scan")

endmodule

`default_nettype wire
